>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the glyph layout RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge while reset is low.
`define GLK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("glk assertion failed");
// Checked on every rising clock edge, reset included.
`define GLK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("glk assertion failed");
`else
`define GLK_ASSERT(label, clk, rst, prop)
`define GLK_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/glk_pkg.sv
// ----------------------------------------------------------------------------
// glk_pkg
// Types, constants and helpers of the glyph layout and kerning block.
// ----------------------------------------------------------------------------
package glk_pkg;

   localparam int MAX_GLYPHS = 256;
   localparam int MAX_PAIRS  = 256;
   localparam int GADDR_W    = $clog2(MAX_GLYPHS);
   localparam int PADDR_W    = $clog2(MAX_PAIRS);
   localparam int CNT_W      = 9;
   localparam int CODE_W     = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_GLYPH   = 2'd0,
      OP_PAIR    = 2'd1,
      OP_RESTART = 2'd2,
      OP_PLACE   = 2'd3
   } glk_op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNING_MODE = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GSCAN,
      ST_KSCAN,
      ST_CALC1,
      ST_CALC2,
      ST_DONE
   } glk_state_type;

   typedef struct packed {
      logic req_ready;
      logic clr_scan;
      logic g_issue;
      logic g_hit;
      logic g_miss;
      logic k_issue;
      logic k_hit;
      logic calc1;
      logic calc2;
      logic load_out;
   } glk_cmd_type;

   typedef struct packed {
      logic       req_valid;
      glk_op_type req_op;
      logic       g_match;
      logic       g_usable;
      logic       g_more;
      logic       g_pend;
      logic       k_skip;
      logic       k_match;
      logic       k_more;
      logic       k_pend;
      logic       out_free;
   } glk_status_type;

   // Clamp a 34-bit signed sum into the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

>>> hdl/glk_req_if.sv
// ----------------------------------------------------------------------------
// glk_req_if
// Request channel: table writes, restarts and characters to place.
// ----------------------------------------------------------------------------
interface glk_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [7:0]         entry_index;
   logic [20:0]        code_point;
   logic [20:0]        second_code_point;
   logic [15:0]        tex_x;
   logic [15:0]        tex_y;
   logic [15:0]        glyph_width;
   logic [15:0]        glyph_height;
   logic signed [15:0] offset_x;
   logic signed [15:0] offset_y;
   logic signed [15:0] advance;
   logic signed [15:0] kern_amount;

   modport source (output valid, opcode, entry_index, code_point, second_code_point,
                   tex_x, tex_y, glyph_width, glyph_height, offset_x, offset_y,
                   advance, kern_amount, input ready);
   modport sink (input valid, opcode, entry_index, code_point, second_code_point,
                 tex_x, tex_y, glyph_width, glyph_height, offset_x, offset_y,
                 advance, kern_amount, output ready);
endinterface

>>> hdl/glk_rsp_if.sv
// ----------------------------------------------------------------------------
// glk_rsp_if
// Response channel: one placement result per placed character.
// ----------------------------------------------------------------------------
interface glk_rsp_if;
   logic               valid;
   logic               ready;
   logic               glyph_found;
   logic signed [31:0] dest_x;
   logic signed [16:0] dest_y;
   logic [15:0]        src_x;
   logic [15:0]        src_y;
   logic [15:0]        src_width;
   logic [15:0]        src_height;
   logic signed [15:0] kerning_applied;
   logic signed [31:0] pen_after;
   logic signed [31:0] string_width;

   modport source (output valid, glyph_found, dest_x, dest_y, src_x, src_y, src_width,
                   src_height, kerning_applied, pen_after, string_width, input ready);
   modport sink (input valid, glyph_found, dest_x, dest_y, src_x, src_y, src_width,
                 src_height, kerning_applied, pen_after, string_width, output ready);
endinterface

>>> hdl/glyph_layout_kerning_top.sv
// ----------------------------------------------------------------------------
// glyph_layout_kerning_top
// Bitmap font text layout with kerning pairs.
// ----------------------------------------------------------------------------
// Glyph writes, pair writes and restarts give no result. Placing a character
// reads glyph slots in order until the first matching code, then kerning slots in
// order until the first matching pair (none when the pair search is skipped),
// since each table has one read port that returns one entry per cycle.
// A new transaction is taken while the previous result waits on the response
// channel; a finished placement waits only if that result has not been taken.
module glyph_layout_kerning_top
   import glk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   glk_req_if.sink               req,
   glk_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   glk_cmd_type    cmd;
   glk_status_type st;

   glk_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   glk_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .st        (st)
   );

endmodule

>>> hdl/glk_ctrl.sv
// ----------------------------------------------------------------------------
// glk_ctrl
// Sequencer: glyph scan, kerning scan, pen arithmetic and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glk_ctrl
   import glk_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  glk_status_type st,
   output glk_cmd_type    cmd
);

   glk_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (st.req_valid && st.req_op == OP_PLACE) state_in = ST_GSCAN;
         end
         ST_GSCAN: begin
            if (st.g_match) begin
               state_in = st.g_usable ? ST_KSCAN : ST_DONE;
            end else if (!st.g_more && !st.g_pend) begin
               state_in = ST_DONE;
            end
         end
         ST_KSCAN: begin
            if (st.k_skip || st.k_match || (!st.k_more && !st.k_pend)) state_in = ST_CALC1;
         end
         ST_CALC1: state_in = ST_CALC2;
         ST_CALC2: state_in = ST_DONE;
         ST_DONE: begin
            if (st.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.clr_scan  = st.req_valid;
         end
         ST_GSCAN: begin
            if (st.g_match) begin
               cmd.g_hit  = st.g_usable;
               cmd.g_miss = !st.g_usable;
            end else if (st.g_more) begin
               cmd.g_issue = 1'b1;
            end else if (!st.g_pend) begin
               cmd.g_miss = 1'b1;
            end
         end
         ST_KSCAN: begin
            if (!st.k_skip) begin
               if (st.k_match) begin
                  cmd.k_hit = 1'b1;
               end else if (st.k_more) begin
                  cmd.k_issue = 1'b1;
               end
            end
         end
         ST_CALC1: cmd.calc1 = 1'b1;
         ST_CALC2: cmd.calc2 = 1'b1;
         ST_DONE:  cmd.load_out = st.out_free;
         default: cmd = '0;
      endcase
   end

   `GLK_ASSERT(a_load_needs_room, clock, reset, cmd.load_out |-> st.out_free)
   `GLK_ASSERT(a_hit_miss_excl, clock, reset, !(cmd.g_hit && cmd.g_miss))
   `GLK_ASSERT(a_place_starts_scan, clock, reset,
      (st.req_valid && cmd.req_ready && st.req_op == OP_PLACE) |=> state_ff == ST_GSCAN)

endmodule

>>> hdl/glk_datapath.sv
// ----------------------------------------------------------------------------
// glk_datapath
// Glyph and kerning tables, scan counters, pen state and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glk_datapath
   import glk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   glk_req_if.sink               req,
   glk_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  glk_cmd_type           cmd,
   output glk_status_type        st
);

   // Configuration registers.
   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic [CNT_W-1:0]   glyph_count_ff, pair_count_ff;
   logic               mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         glyph_count_ff <= '0;
         pair_count_ff  <= '0;
         mode_ff        <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X:     origin_x_ff    <= csr_wdata;
            CSR_ORIGIN_Y:     origin_y_ff    <= csr_wdata;
            CSR_GLYPH_COUNT:  glyph_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_PAIR_COUNT:   pair_count_ff  <= csr_wdata[CNT_W-1:0];
            CSR_KERNING_MODE: mode_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign req.ready = cmd.req_ready;
   assign accept    = req.valid && cmd.req_ready;

   // Tables.
   logic [CODE_W-1:0]   gcode_mem [MAX_GLYPHS];
   logic [63:0]         gplace_mem [MAX_GLYPHS];
   logic [47:0]         gmetric_mem [MAX_GLYPHS];
   logic [2*CODE_W-1:0] kkey_mem [MAX_PAIRS];
   logic [15:0]         kamt_mem [MAX_PAIRS];

   logic [CNT_W-1:0]    gcnt_ff, gcnt_in, kcnt_ff, kcnt_in;
   logic [CODE_W-1:0]   gcode_q;
   logic [63:0]         gplace_q;
   logic [47:0]         gmetric_q;
   logic [2*CODE_W-1:0] kkey_q;
   logic signed [15:0]  kamt_q;

   always_ff @(posedge clock) begin
      if (accept && req.opcode == OP_GLYPH) begin
         gcode_mem[req.entry_index[GADDR_W-1:0]]   <= req.code_point;
         gplace_mem[req.entry_index[GADDR_W-1:0]]  <= {req.glyph_height, req.glyph_width,
                                                       req.tex_y, req.tex_x};
         gmetric_mem[req.entry_index[GADDR_W-1:0]] <= {req.advance, req.offset_y,
                                                       req.offset_x};
      end
      gcode_q   <= gcode_mem[gcnt_ff[GADDR_W-1:0]];
      gplace_q  <= gplace_mem[gcnt_ff[GADDR_W-1:0]];
      gmetric_q <= gmetric_mem[gcnt_ff[GADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && req.opcode == OP_PAIR) begin
         kkey_mem[req.entry_index[PADDR_W-1:0]] <= {req.code_point, req.second_code_point};
         kamt_mem[req.entry_index[PADDR_W-1:0]] <= req.kern_amount;
      end
      kkey_q <= kkey_mem[kcnt_ff[PADDR_W-1:0]];
      kamt_q <= kamt_mem[kcnt_ff[PADDR_W-1:0]];
   end

   // Scan counters; the pending flag marks a read whose data arrives this cycle.
   logic gpend_ff, kpend_ff;
   logic [CNT_W-1:0] gn, pn;

   assign gn = (glyph_count_ff > CNT_W'(MAX_GLYPHS)) ? CNT_W'(MAX_GLYPHS) : glyph_count_ff;
   assign pn = (pair_count_ff > CNT_W'(MAX_PAIRS)) ? CNT_W'(MAX_PAIRS) : pair_count_ff;

   always_comb begin
      gcnt_in = gcnt_ff;
      kcnt_in = kcnt_ff;
      if (cmd.clr_scan) begin
         gcnt_in = '0;
         kcnt_in = '0;
      end else begin
         if (cmd.g_issue) gcnt_in = gcnt_ff + CNT_W'(1);
         if (cmd.k_issue) kcnt_in = kcnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gcnt_ff  <= '0;
         kcnt_ff  <= '0;
         gpend_ff <= 1'b0;
         kpend_ff <= 1'b0;
      end else begin
         gcnt_ff  <= gcnt_in;
         kcnt_ff  <= kcnt_in;
         gpend_ff <= cmd.g_issue;
         kpend_ff <= cmd.k_issue;
      end
   end

   // Hit capture and arithmetic.
   logic               found_ff;
   logic [63:0]        hplace_ff;
   logic [47:0]        hmetric_ff;
   logic signed [15:0] kern_ff, kern_neg;
   logic signed [31:0] x1_ff, dx_ff, pa_ff;
   logic signed [16:0] dy_ff;

   // Item and string state.
   logic [CODE_W-1:0]  code_ff, prev_ff;
   logic signed [31:0] pen_ff;

   always_ff @(posedge clock) begin
      if (accept) code_ff <= req.code_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff  <= '0;
         prev_ff <= '0;
      end else if (accept && req.opcode == OP_RESTART) begin
         pen_ff  <= 32'(origin_x_ff);
         prev_ff <= '0;
      end else if (cmd.load_out && found_ff) begin
         pen_ff  <= pa_ff;
         prev_ff <= code_ff;
      end
   end

   assign kern_neg = (kamt_q == 16'sh8000) ? 16'sh7fff : 16'(-kamt_q);

   always_ff @(posedge clock) begin
      if (cmd.g_hit) begin
         found_ff   <= 1'b1;
         hplace_ff  <= gplace_q;
         hmetric_ff <= gmetric_q;
         kern_ff    <= '0;
      end
      if (cmd.g_miss) begin
         found_ff <= 1'b0;
         pa_ff    <= pen_ff;
      end
      if (cmd.k_hit) kern_ff <= mode_ff ? kern_neg : kamt_q;
      if (cmd.calc1) x1_ff <= sat32(34'(pen_ff) + 34'(kern_ff));
      if (cmd.calc2) begin
         dx_ff <= sat32(34'(x1_ff) + 34'($signed(hmetric_ff[15:0])));
         pa_ff <= sat32(34'(x1_ff) + 34'($signed(hmetric_ff[47:32])));
         dy_ff <= 17'(origin_y_ff) + 17'($signed(hmetric_ff[31:16]));
      end
   end

   // Result register.
   logic               rsp_valid_ff;
   logic               o_found_ff;
   logic signed [31:0] o_dx_ff, o_pa_ff, o_sw_ff;
   logic signed [16:0] o_dy_ff;
   logic [63:0]        o_place_ff;
   logic signed [15:0] o_kern_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_found_ff <= found_ff;
         o_dx_ff    <= found_ff ? dx_ff : '0;
         o_dy_ff    <= found_ff ? dy_ff : '0;
         o_place_ff <= found_ff ? hplace_ff : '0;
         o_kern_ff  <= found_ff ? kern_ff : '0;
         o_pa_ff    <= pa_ff;
         o_sw_ff    <= sat32(34'(pa_ff) - 34'(origin_x_ff));
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.glyph_found     = o_found_ff;
   assign rsp.dest_x          = o_dx_ff;
   assign rsp.dest_y          = o_dy_ff;
   assign rsp.src_x           = o_place_ff[15:0];
   assign rsp.src_y           = o_place_ff[31:16];
   assign rsp.src_width       = o_place_ff[47:32];
   assign rsp.src_height      = o_place_ff[63:48];
   assign rsp.kerning_applied = o_kern_ff;
   assign rsp.pen_after       = o_pa_ff;
   assign rsp.string_width    = o_sw_ff;

   // Status toward the sequencer.
   always_comb begin
      st.req_valid = req.valid;
      st.req_op    = glk_op_type'(req.opcode);
      st.g_match   = gpend_ff && gcode_q == code_ff;
      st.g_usable  = !(mode_ff && gplace_q[47:32] == 16'd0);
      st.g_more    = gcnt_ff < gn;
      st.g_pend    = gpend_ff;
      st.k_skip    = mode_ff && (prev_ff == '0 || code_ff == '0);
      st.k_match   = kpend_ff && kkey_q == {prev_ff, code_ff};
      st.k_more    = kcnt_ff < pn;
      st.k_pend    = kpend_ff;
      st.out_free  = !rsp_valid_ff || rsp.ready;
   end

   `GLK_ASSERT(a_rsp_from_load, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.load_out))
   `GLK_ASSERT(a_gcnt_step, clock, reset,
      (cmd.g_issue && !cmd.clr_scan) |=> gcnt_ff == CNT_W'($past(gcnt_ff) + CNT_W'(1)))
   `GLK_ASSERT(a_pen_hold, clock, reset, (!cmd.load_out && !accept) |=> $stable(pen_ff))

endmodule
